// ----- sv/dhb_pkg.sv -----
// Shared types and constants for the half-size downscaler.
`default_nettype none
package dhb_pkg;
   localparam int MaxWidth    = 4096;
   localparam int MaxChannels = 4;
   localparam int ColW        = $clog2(MaxWidth);
   localparam int PixW        = 8 * MaxChannels;

   localparam logic [1:0] CsrMode   = 2'd0;
   localparam logic [1:0] CsrWidth  = 2'd1;
   localparam logic [1:0] CsrHeight = 2'd2;
   localparam logic [1:0] CsrChan   = 2'd3;

   typedef struct packed {
      logic [7:0] sample_ch3;
      logic [7:0] sample_ch2;
      logic [7:0] sample_ch1;
      logic [7:0] sample_ch0;
   } req_word_type;

   typedef struct packed {
      logic       frame_done;
      logic [7:0] out_ch3;
      logic [7:0] out_ch2;
      logic [7:0] out_ch1;
      logic [7:0] out_ch0;
   } rsp_word_type;

   typedef struct packed {
      logic        mode;
      logic [13:0] width;
      logic [15:0] height;
      logic [2:0]  chan;
   } cfg_type;

   function automatic logic [7:0] lane(input logic [PixW-1:0] p, input int k);
      lane = p[8*k +: 8];
   endfunction

   function automatic logic [PixW-1:0] box4(input logic [PixW-1:0] a, b, c, d);
      logic [9:0] s;
      box4 = '0;
      for (int k = 0; k < MaxChannels; k++) begin
         s = {2'b0, lane(a, k)} + {2'b0, lane(b, k)} + {2'b0, lane(c, k)} + {2'b0, lane(d, k)};
         box4[8*k +: 8] = s[9:2];
      end
   endfunction
endpackage
`default_nettype wire

// ----- sv/dhb_rowstore.sv -----
// Two row stores and the window column registers.
`default_nettype none
module dhb_rowstore
   import dhb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic [ColW-1:0] col,
   input  wire logic [ColW-1:0] rd_col,
   input  wire logic [PixW-1:0] cur,
   output logic      [PixW-1:0] u_rd,
   output logic      [PixW-1:0] m_rd,
   output logic      [PixW-1:0] up1_ff, up2_ff, mp1_ff, mp2_ff, cp1_ff, cp2_ff
);
   logic [PixW-1:0] upper_mem [MaxWidth];
   logic [PixW-1:0] middle_mem [MaxWidth];
   logic [PixW-1:0] u_rd_ff, m_rd_ff;

   // fetch the next pixel's column ahead into a register; it never equals the written column
   always_ff @(posedge clock) begin
      u_rd_ff <= upper_mem[rd_col];
      m_rd_ff <= middle_mem[rd_col];
   end
   assign u_rd = u_rd_ff;
   assign m_rd = m_rd_ff;

   // shift rows down on each accepted pixel
   always_ff @(posedge clock) begin
      if (adv) begin
         upper_mem[col]  <= m_rd_ff;
         middle_mem[col] <= cur;
      end
   end

   // advance the column registers
   always_ff @(posedge clock) begin
      if (reset) begin
         up1_ff <= '0; up2_ff <= '0; mp1_ff <= '0;
         mp2_ff <= '0; cp1_ff <= '0; cp2_ff <= '0;
      end else if (adv) begin
         up2_ff <= up1_ff; up1_ff <= u_rd_ff;
         mp2_ff <= mp1_ff; mp1_ff <= m_rd_ff;
         cp2_ff <= cp1_ff; cp1_ff <= cur;
      end
   end
endmodule
`default_nettype wire

// ----- sv/dhb_filter.sv -----
// Window arithmetic: 3x3, 2x3 and 2x2 kernels per lane.
`default_nettype none
module dhb_filter
   import dhb_pkg::*;
(
   input  wire logic [PixW-1:0] t0, t1, t2, m0, m1, m2, b0, b1, b2,
   output logic      [PixW-1:0] w9,
   output logic      [PixW-1:0] w6,
   output logic      [PixW-1:0] bx
);
   logic [11:0] s9;
   logic [10:0] s6;
   // weigh each lane
   always_comb begin
      w9 = '0;
      w6 = '0;
      s9 = '0;
      s6 = '0;
      for (int k = 0; k < MaxChannels; k++) begin
         s9 = 12'(lane(t0, k)) + 12'(lane(t1, k)) + 12'(lane(t2, k))
            + 12'(lane(m0, k)) + 12'(lane(m1, k)) * 12'd5 + {3'b0, lane(m2, k), 1'b0}
            + 12'(lane(b0, k)) + {3'b0, lane(b1, k), 1'b0} + {3'b0, lane(b2, k), 1'b0};
         w9[8*k +: 8] = s9[11:4];
         s6 = 11'(lane(m0, k)) + 11'(lane(m1, k)) + 11'(lane(m2, k))
            + 11'(lane(b0, k)) + 11'(lane(b1, k)) * 11'd3 + 11'(lane(b2, k));
         w6[8*k +: 8] = s6[10:3];
      end
      bx = box4(m1, m2, b1, b2);
   end
endmodule
`default_nettype wire

// ----- sv/downscale_half_box_or_weighted_top.sv -----
// Top level of the half-size downscaler.
// Throughput: one pixel per cycle while req_stall is low; the output register and a skid word decouple stall.
// Row stores are read ahead at the next pixel's column, written at the current one.
// Reset (synchronous, active high) clears position, column registers and held pixel,
// and loads the default configuration; row store contents stay undefined until written.
`default_nettype none
module downscale_half_box_or_weighted_top
   import dhb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   cfg_type cfg_ff;
   logic [ColW-1:0] col_ff, col_in;
   logic [15:0]     row_ff, row_in;
   logic [PixW-1:0] held_ff;
   logic            ov_ff, sv_ff;
   rsp_word_type    skid_ff;

   assign csr_ready = 1'b1;
   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 1'b0, width: 14'd2, height: 16'd2, chan: 3'd3};
      end else if (csr_valid) begin
         case (csr_index)
            CsrMode:   cfg_ff.mode   <= csr_wdata[0];
            CsrWidth:  cfg_ff.width  <= {1'b0, csr_wdata[12:0]};
            CsrHeight: cfg_ff.height <= csr_wdata[15:0];
            CsrChan:   cfg_ff.chan   <= csr_wdata[2:0];
            default:   cfg_ff.mode   <= cfg_ff.mode;
         endcase
      end
   end

   // clamp configuration
   logic [2:0]  cc;
   logic [13:0] w;
   logic [15:0] h;
   always_comb begin
      cc = (cfg_ff.chan == 3'd0) ? 3'd1
         : (cfg_ff.chan > 3'(MaxChannels)) ? 3'(MaxChannels) : cfg_ff.chan;
      w  = (cfg_ff.width < 14'd2) ? 14'd2
         : (cfg_ff.width > 14'(MaxWidth)) ? 14'(MaxWidth) : cfg_ff.width;
      h  = (cfg_ff.height < 16'd2) ? 16'd2 : cfg_ff.height;
   end

   logic adv;
   assign req_stall = sv_ff;
   assign adv = req_valid && !req_stall;

   logic [PixW-1:0] cur;
   always_comb begin
      cur = '0;
      for (int k = 0; k < MaxChannels; k++)
         if (3'(k) < cc) cur[8*k +: 8] = req_data[8*k +: 8];
   end

   logic [PixW-1:0] u_rd, m_rd, up1, up2, mp1, mp2, cp1, cp2;
   dhb_rowstore u_rs (
      .clock, .reset, .adv, .col(col_ff), .rd_col(col_in), .cur, .u_rd, .m_rd,
      .up1_ff(up1), .up2_ff(up2), .mp1_ff(mp1), .mp2_ff(mp2), .cp1_ff(cp1), .cp2_ff(cp2)
   );

   logic [PixW-1:0] w9, w6, bx;
   dhb_filter u_flt (
      .t0(up2), .t1(up1), .t2(u_rd), .m0(mp2), .m1(mp1), .m2(m_rd),
      .b0(cp2), .b1(cp1), .b2(cur), .w9, .w6, .bx
   );

   // select the result for this pixel
   logic [13:0] colx;
   logic last_row, last_col, even_band, hit, done;
   logic [PixW-1:0] res;
   rsp_word_type res_word;
   always_comb begin
      colx = {1'b0, col_ff};
      last_row = row_ff == h - 16'd1;
      last_col = colx == w - 14'd1;
      even_band = !row_ff[0] && row_ff >= 16'd2;
      hit = 1'b0; done = 1'b0; res = bx;
      if (!cfg_ff.mode) begin
         hit = row_ff[0] && col_ff[0];
         done = row_ff == h - 16'd1 - 16'(h[0]) && colx == w - 14'd1 - 14'(w[0]);
      end else begin
         if (even_band && !col_ff[0] && colx >= 14'd2) begin
            hit = 1'b1; res = w9;
         end else if (even_band && !w[0] && last_col) begin
            hit = 1'b1; res = held_ff;
         end else if (!h[0] && last_row && !col_ff[0] && colx >= 14'd2) begin
            hit = 1'b1; res = w6;
         end else if (!h[0] && !w[0] && last_row && last_col) begin
            hit = 1'b1; res = bx;
         end
         done = last_row && last_col;
      end
      res_word = '0;
      res_word.out_ch0 = res[7:0];
      res_word.out_ch1 = (cc > 3'd1) ? res[15:8] : 8'd0;
      res_word.out_ch2 = (cc > 3'd2) ? res[23:16] : 8'd0;
      res_word.out_ch3 = (cc > 3'd3) ? res[31:24] : 8'd0;
      res_word.frame_done = done;
   end

   // next position, also the row store read address
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (reset) begin
         col_in = '0;
         row_in = '0;
      end else if (adv) begin
         if (colx + 14'd1 >= w) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} + 17'd1 >= {1'b0, h}) ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   // positions and held edge pixel
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      if (reset) begin
         held_ff <= '0;
      end else if (adv && cfg_ff.mode && row_ff[0] && last_col) begin
         held_ff <= bx;
      end
   end

   // output register with skid word
   logic push, pop;
   assign push = adv && hit;
   assign pop = ov_ff && !rsp_stall;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; sv_ff <= 1'b0;
      end else begin
         if (!ov_ff || pop) begin
            ov_ff <= sv_ff || push;
            sv_ff <= sv_ff && push;
         end else begin
            sv_ff <= sv_ff || push;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (!ov_ff || pop) begin
         rsp_data <= sv_ff ? skid_ff : res_word;
         if (sv_ff && push) skid_ff <= res_word;
      end else if (push && !sv_ff) begin
         skid_ff <= res_word;
      end
   end
   assign rsp_valid = ov_ff;
endmodule
`default_nettype wire

// ----- sv/dhb_checker.sv -----
// Port-level checks for the downscaler, bound to the top level.
`default_nettype none
module dhb_checker
   import dhb_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("stall without backlog");
endmodule
bind downscale_half_box_or_weighted_top dhb_checker u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
`default_nettype wire
